// File: src/pcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

	localparam int RADIUS_BITS_DEF    = 10;
	localparam int STEPS_PER_UNIT_DEF = 20;

	localparam int CENTER_W     = 11;
	localparam int RADIUS_CFG_W = 10;
	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 2;
	localparam int COORD_W      = 12;
	localparam int OCT_W        = 3;
	localparam int STEP_W       = 14;
	localparam int FRAC_BITS    = 8;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;
	localparam logic [OCT_W-1:0]  OCT_LAST = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_RADIUS   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              restart;
		logic              mul;
		logic              scale;
		logic              prep;
		logic              root;
		logic              round;
		logic              load_out;
		logic              advance;
		logic [OCT_W-1:0]  octant;
	} pcp_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} pcp_sts_t;

endpackage

`default_nettype wire

// File: src/pcp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcp_ctrl #(
	parameter int ROOT_STEPS = pcp_pkg::RADIUS_BITS_DEF + pcp_pkg::FRAC_BITS
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               start_req,
	output logic              in_ready,
	input  pcp_pkg::pcp_sts_t sts,
	output pcp_pkg::pcp_cmd_t cmd
);

	localparam int CNT_W = $clog2(ROOT_STEPS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SCALE,
		S_PREP,
		S_ROOT,
		S_ROUND,
		S_EMIT
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [pcp_pkg::OCT_W-1:0]  oct_q;
	logic                       active_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.restart  = (state_q == S_IDLE) && in_valid && start_req;
		cmd.mul      = (state_q == S_MUL);
		cmd.scale    = (state_q == S_SCALE);
		cmd.prep     = (state_q == S_PREP);
		cmd.root     = (state_q == S_ROOT);
		cmd.round    = (state_q == S_ROUND);
		cmd.load_out = (state_q == S_EMIT) && sts.out_free;
		cmd.advance  = cmd.load_out && (oct_q == pcp_pkg::OCT_LAST);
		cmd.octant   = oct_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			oct_q    <= '0;
			active_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (start_req) begin
							active_q <= 1'b1;
							state_q  <= S_MUL;
						end else if (active_q) begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_PREP;
				S_PREP: begin
					cnt_q   <= CNT_W'(ROOT_STEPS - 1);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= S_ROUND;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ROUND: begin
					oct_q   <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.out_free) begin
						if (oct_q == pcp_pkg::OCT_LAST) begin
							active_q <= !sts.done;
							state_q  <= S_IDLE;
						end else begin
							oct_q <= oct_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/pcp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pcp_datapath #(
	parameter int RADIUS_BITS    = pcp_pkg::RADIUS_BITS_DEF,
	parameter int STEPS_PER_UNIT = pcp_pkg::STEPS_PER_UNIT_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [pcp_pkg::CFG_IDX_W-1:0]           cfg_addr,
	input  wire [pcp_pkg::CFG_W-1:0]               cfg_data,
	input  pcp_pkg::pcp_cmd_t                      cmd,
	output pcp_pkg::pcp_sts_t                      sts,
	input  wire                                    out_ready,
	output logic                                   out_valid,
	output logic signed [pcp_pkg::COORD_W-1:0]     pixel_x,
	output logic signed [pcp_pkg::COORD_W-1:0]     pixel_y,
	output logic [pcp_pkg::OCT_W-1:0]              octant,
	output logic                                   last_of_step,
	output logic                                   circle_done
);

	localparam int RW    = (RADIUS_BITS < pcp_pkg::RADIUS_CFG_W) ?
	                       RADIUS_BITS : pcp_pkg::RADIUS_CFG_W;
	localparam int S2    = STEPS_PER_UNIT * STEPS_PER_UNIT;
	localparam int S2W   = $clog2(S2 + 1);
	localparam int YB    = RW + pcp_pkg::FRAC_BITS;
	localparam int RSW   = 2 * RW + S2W;
	localparam int NSW   = 2 * pcp_pkg::STEP_W;
	localparam int N1W   = NSW + 1;
	localparam int CW    = (RSW > N1W + 1) ? RSW : N1W + 1;
	localparam int W     = RSW + 2 * pcp_pkg::FRAC_BITS;
	localparam int REM_W = $clog2(STEPS_PER_UNIT + 1);
	localparam int CTW   = pcp_pkg::COORD_W;
	localparam int SW    = pcp_pkg::STEP_W;
	localparam int FB    = pcp_pkg::FRAC_BITS;
	localparam int CXW   = pcp_pkg::CENTER_W;

	localparam logic [REM_W:0]   S_CMP    = (REM_W + 1)'(STEPS_PER_UNIT);
	localparam logic [REM_W-1:0] REM_LAST = REM_W'(STEPS_PER_UNIT - 1);
	localparam logic [FB-1:0]    Y_HALF   = FB'(1 << (FB - 1));

	// configuration
	logic signed [CXW-1:0] center_x_q;
	logic signed [CXW-1:0] center_y_q;
	logic [RW-1:0]         radius_q;

	// step position: n = q * STEPS_PER_UNIT + rem
	logic [SW-1:0]    n_q;
	logic [SW-1:0]    q_q;
	logic [REM_W-1:0] rem_q;

	logic [2*RW-1:0]  r2_q;
	logic [NSW-1:0]   n2_q;
	logic [RSW-1:0]   rs2_q;
	logic [N1W-1:0]   n1sq_q;
	logic             done_q;

	// square root: res holds 65536*a - S2*y^2, u and dv the scaled trial terms
	logic [W-1:0]     res_q;
	logic [W-1:0]     u_q;
	logic [W-1:0]     dv_q;
	logic [YB-1:0]    y_q;

	logic [CTW-1:0]   xp_q;
	logic [CTW-1:0]   xm_q;
	logic [CTW-1:0]   yp_q;
	logic [CTW-1:0]   ym_q;

	logic [W:0]       trial;
	logic             take;
	logic [W-1:0]     u_up;
	logic [RSW-1:0]   diff;
	logic [CTW-1:0]   cx12;
	logic [CTW-1:0]   cy12;
	logic [CTW-1:0]   px;
	logic [CTW-1:0]   py;
	logic [RW-1:0]    yi;
	logic [FB-1:0]    yf;
	logic [CTW-1:0]   xi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				pcp_pkg::CFG_CENTER_X: center_x_q <= cfg_data[CXW-1:0];
				pcp_pkg::CFG_CENTER_Y: center_y_q <= cfg_data[CXW-1:0];
				pcp_pkg::CFG_RADIUS:   radius_q   <= cfg_data[RW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			q_q   <= '0;
			rem_q <= '0;
		end else if (cmd.restart || (cmd.advance && done_q)) begin
			n_q   <= '0;
			q_q   <= '0;
			rem_q <= '0;
		end else if (cmd.advance) begin
			n_q <= n_q + 1'b1;
			if (rem_q == REM_LAST) begin
				rem_q <= '0;
				q_q   <= q_q + 1'b1;
			end else begin
				rem_q <= rem_q + 1'b1;
			end
		end
	end

	assign trial = {1'b0, u_q} + {1'b0, dv_q};
	assign take  = ({1'b0, res_q} >= trial);
	assign u_up  = u_q + (dv_q << 1);
	assign diff  = rs2_q - RSW'(n2_q);

	assign yi = y_q[YB-1:FB];
	assign yf = y_q[FB-1:0];
	assign xi = q_q[CTW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			r2_q <= radius_q * radius_q;
			n2_q <= n_q * n_q;
		end
		if (cmd.scale) begin
			rs2_q  <= {{S2W{1'b0}}, r2_q} * RSW'(S2);
			n1sq_q <= {1'b0, n2_q} + {{SW{1'b0}}, n_q, 1'b0} + N1W'(1);
		end
		if (cmd.prep) begin
			if (CW'(rs2_q) > CW'(n2_q)) begin
				res_q <= {diff, {(2 * FB){1'b0}}};
			end else begin
				res_q <= '0;
			end
			done_q <= (CW'({n1sq_q, 1'b0}) > CW'(rs2_q)) || (n_q == pcp_pkg::STEP_MAX);
			u_q    <= '0;
			dv_q   <= W'(S2) << (2 * (YB - 1));
			y_q    <= '0;
		end
		if (cmd.root) begin
			if (take) begin
				res_q <= res_q - trial[W-1:0];
				u_q   <= u_up >> 1;
			end else begin
				u_q <= u_q >> 1;
			end
			dv_q <= dv_q >> 2;
			y_q  <= {y_q[YB-2:0], take};
		end
		if (cmd.round) begin
			xp_q <= xi + CTW'({rem_q, 1'b0} >= S_CMP);
			xm_q <= CTW'(0) - (xi + CTW'({rem_q, 1'b0} > S_CMP));
			yp_q <= CTW'(yi) + CTW'(yf >= Y_HALF);
			ym_q <= CTW'(0) - (CTW'(yi) + CTW'(yf > Y_HALF));
		end
	end

	assign cx12 = {{(CTW - CXW){center_x_q[CXW-1]}}, center_x_q};
	assign cy12 = {{(CTW - CXW){center_y_q[CXW-1]}}, center_y_q};

	always_comb begin
		case (cmd.octant)
			3'd0: begin px = cx12 + xp_q; py = cy12 + yp_q; end
			3'd1: begin px = cx12 + yp_q; py = cy12 + xp_q; end
			3'd2: begin px = cx12 + yp_q; py = cy12 + xm_q; end
			3'd3: begin px = cx12 + xp_q; py = cy12 + ym_q; end
			3'd4: begin px = cx12 + xm_q; py = cy12 + ym_q; end
			3'd5: begin px = cx12 + ym_q; py = cy12 + xm_q; end
			3'd6: begin px = cx12 + ym_q; py = cy12 + xp_q; end
			3'd7: begin px = cx12 + xm_q; py = cy12 + yp_q; end
			default: begin px = cx12; py = cy12; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pixel_x      <= px;
			pixel_y      <= py;
			octant       <= cmd.octant;
			last_of_step <= (cmd.octant == pcp_pkg::OCT_LAST);
			circle_done  <= done_q;
		end
	end

	assign sts.done     = done_q;
	assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: src/polynomial_circle_plotter.sv
`timescale 1ns / 1ps
`default_nettype none

// Circle plotter with eight-way symmetry. Write center_x, center_y and radius,
// then send ticks: start_req=1 begins a circle at step zero, start_req=0 plots
// the next step (x advances by 1/STEPS_PER_UNIT pixel). Each plotted step gives
// eight pixels, octant 0..7, with circle_done set on all eight of the final
// step; ticks with no circle in progress give nothing. A plotted step runs
// through the setup states for the squares (S_MUL, S_SCALE, S_PREP), the
// iterative square root at one result bit per cycle (RADIUS_BITS + 8 bits,
// RADIUS_BITS counted at most 10), the rounding state, eight pixels through
// the single output register, which waits on out_ready, and the idle state
// that takes the next tick; no new tick is taken before the step is through.

module polynomial_circle_plotter #(
	parameter int RADIUS_BITS    = pcp_pkg::RADIUS_BITS_DEF,
	parameter int STEPS_PER_UNIT = pcp_pkg::STEPS_PER_UNIT_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [pcp_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  wire [pcp_pkg::CFG_W-1:0]           cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                start_req,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [pcp_pkg::COORD_W-1:0] pixel_x,
	output logic signed [pcp_pkg::COORD_W-1:0] pixel_y,
	output logic [pcp_pkg::OCT_W-1:0]          octant,
	output logic                               last_of_step,
	output logic                               circle_done
);

	localparam int RW = (RADIUS_BITS < pcp_pkg::RADIUS_CFG_W) ?
	                    RADIUS_BITS : pcp_pkg::RADIUS_CFG_W;

	pcp_pkg::pcp_cmd_t cmd;
	pcp_pkg::pcp_sts_t sts;

	pcp_ctrl #(
		.ROOT_STEPS(RW + pcp_pkg::FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.start_req(start_req),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcp_datapath #(
		.RADIUS_BITS   (RADIUS_BITS),
		.STEPS_PER_UNIT(STEPS_PER_UNIT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.octant      (octant),
		.last_of_step(last_of_step),
		.circle_done (circle_done)
	);

	// a pending pixel other than the last keeps new ticks out
	a_busy_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_step) |-> !in_ready)
		else $error("tick accepted in the middle of a step");

	// pixels of one step follow each other without gaps
	a_octant_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_step) |=>
		(out_valid && (octant == $past(octant) + 3'd1)))
		else $error("octant sequence broken");

	a_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_step) |=>
		(circle_done == $past(circle_done)))
		else $error("circle_done changed within a step");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_step == (octant == pcp_pkg::OCT_LAST)))
		else $error("last_of_step does not match octant");

endmodule

`default_nettype wire
